[rtl/mbps_pkg.sv]
package mbps_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int LEN_BITS      = 5;
   localparam int CARE_BITS     = 16;
   localparam int WORD_BITS     = 64;
   localparam int PATTERN_BITS  = 2 * WORD_BITS;
   localparam int RESULT_BITS   = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam int DEFAULT_MAX_PATTERN = 16;
   localparam int DEFAULT_OFFSET_BITS = 32;

   localparam logic [CARE_BITS-1:0] CARE_RESET = '1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PATTERN_LEN  = 2'd0,
      CSR_PATTERN_LOW  = 2'd1,
      CSR_PATTERN_HIGH = 2'd2,
      CSR_CARE_MASK    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic                   found;
      logic [RESULT_BITS-1:0] match_offset;
   } result_type;

   function automatic logic [7:0] pick_byte(input logic [PATTERN_BITS-1:0] pattern,
                                            input logic [3:0]              idx);
      pick_byte = pattern[idx*8 +: 8];
   endfunction

endpackage

[rtl/mbps_cell.sv]
module mbps_cell
   import mbps_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  cell_ctl_type            ctl,
   input  logic [7:0]              shift_in,
   input  logic [LEN_BITS-1:0]     len,
   input  logic [PATTERN_BITS-1:0] pattern,
   input  logic [CARE_BITS-1:0]    care,
   output logic [7:0]              byte_out,
   output logic                    hit
);

   logic [7:0]          byte_ff;
   logic [7:0]          byte_in;
   logic [3:0]          sel;
   logic                active;
   logic                care_bit;

   // pattern byte aligned to this window position for the current length
   assign active   = len > LEN_BITS'(IDX);
   assign sel      = 4'(len - LEN_BITS'(1) - LEN_BITS'(IDX));
   assign care_bit = active & care[sel];
   assign hit      = !care_bit || (shift_in == pick_byte(pattern, sel));

   always_comb begin
      byte_in = byte_ff;
      if (ctl.clear) begin
         byte_in = '0;
      end else if (ctl.shift) begin
         byte_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

[rtl/mbps_out_buf.sv]
module mbps_out_buf
   import mbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       push_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // skid entry only ever backs up a full main entry
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without main entry");

   // no push may land while the skid entry is occupied
   assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("push into full buffer");

   // a stalled main entry is kept
   assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> main_valid_ff)
      else $error("main entry lost while stalled");

endmodule

[rtl/masked_byte_pattern_search.sv]
// a result beat is registered in the output buffer before it is offered
// one byte beat per cycle unless stalled, every cell compares its window byte in that
// cycle; a two-entry output buffer keeps bytes flowing while one result waits; with two
// results waiting the input stalls until one is taken
// reset (synchronous): clears count, match flag and output buffer, the window clears at
// each region end; pattern length and bytes go to zero and the care mask to all ones
module masked_byte_pattern_search
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
   parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_region_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [RESULT_BITS-1:0]  rsp_match_offset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_data
);

   localparam int WIDE_BITS = (OFFSET_BITS > RESULT_BITS) ? OFFSET_BITS : RESULT_BITS;

   logic [LEN_BITS-1:0]    pat_len_ff;
   logic [WORD_BITS-1:0]   pattern_low_ff;
   logic [WORD_BITS-1:0]   pattern_high_ff;
   logic [CARE_BITS-1:0]   care_mask_ff;
   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                   match_reported_ff, match_reported_in;

   logic [LEN_BITS-1:0]     len_eff;
   logic [PATTERN_BITS-1:0] pattern;
   logic [7:0]              window [MAX_PATTERN];
   logic [7:0]              cell_in [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]  hits;
   cell_ctl_type            cell_ctl;
   logic                    accept;
   logic                    live;
   logic [OFFSET_BITS-1:0]  count_next;
   logic [OFFSET_BITS-1:0]  diff;
   logic [WIDE_BITS-1:0]    diff_wide;
   logic                    match;
   logic                    push;
   logic                    push_ready;
   result_type              push_data;
   result_type              out_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff      <= '0;
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= CARE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LEN:  pat_len_ff      <= csr_data[LEN_BITS-1:0];
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_data;
            CSR_CARE_MASK:    care_mask_ff    <= csr_data[CARE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign len_eff = (pat_len_ff > LEN_BITS'(MAX_PATTERN)) ?
                    LEN_BITS'(MAX_PATTERN) : pat_len_ff;
   assign pattern = {pattern_high_ff, pattern_low_ff};

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign live      = accept && !match_reported_ff;

   assign cell_ctl.shift = live;
   assign cell_ctl.clear = accept && req_region_end;

   // window as a row of cells, newest byte in cell 0
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_in[k] = req_data_byte;
      end else begin : g_link
         assign cell_in[k] = window[k-1];
      end
      mbps_cell #(.IDX(k)) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .shift_in (cell_in[k]),
         .len      (len_eff),
         .pattern  (pattern),
         .care     (care_mask_ff),
         .byte_out (window[k]),
         .hit      (hits[k])
      );
   end

   assign count_next = (bytes_seen_ff == {OFFSET_BITS{1'b1}}) ?
                       bytes_seen_ff : bytes_seen_ff + OFFSET_BITS'(1);
   assign diff       = count_next - OFFSET_BITS'(len_eff);
   assign diff_wide  = WIDE_BITS'(diff);
   assign match      = (len_eff != '0) && (count_next >= OFFSET_BITS'(len_eff)) && (&hits);

   always_comb begin
      bytes_seen_in     = bytes_seen_ff;
      match_reported_in = match_reported_ff;
      if (accept && req_region_end) begin
         bytes_seen_in     = '0;
         match_reported_in = 1'b0;
      end else if (live) begin
         bytes_seen_in     = count_next;
         match_reported_in = match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
      end else begin
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
      end
   end

   assign push                   = live && (match || req_region_end);
   assign push_data.found        = match;
   assign push_data.match_offset = match ? diff_wide[RESULT_BITS-1:0] : '0;

   mbps_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_found        = out_data.found;
   assign rsp_match_offset = out_data.match_offset;

   // bytes after a reported match give no result
   assert property (@(posedge clock) disable iff (reset)
      (accept && match_reported_ff) |-> !push)
      else $error("result after reported match");

   // a found result sets the flag unless the region ends on that byte
   assert property (@(posedge clock) disable iff (reset)
      (push && match && !req_region_end) |=> match_reported_ff)
      else $error("match flag not set");

   // region end always leaves a fresh count and clear flag
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_region_end) |=> (bytes_seen_ff == '0) && !match_reported_ff)
      else $error("region not restarted");

endmodule
